>>> hdl/assert_macros.svh
// Assertion macros of the euclidean rhythm generator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define ERG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, switched off while reset is held
`define ERG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define ERG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

>>> hdl/erg_pkg.sv
// Shared types and constants of the euclidean rhythm generator
package erg_pkg;

  // Default pattern length limit
  localparam int STEP_LIMIT_DEF = 16;

  // Port field widths
  localparam int STEP_W = 5;
  localparam int HIT_W  = 5;
  localparam int ROT_W  = 4;
  localparam int PAT_W  = 16;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_LEVEL,
    ST_EXPAND,
    ST_NORM,
    ST_ROT,
    ST_FINISH
  } erg_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic level_wr;
    logic exp_step;
    logic norm_step;
    logic rot_step;
    logic out_load;
  } erg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic zero_case;
    logic div_last;
    logic lvl_more;
    logic exp_done;
    logic norm_done;
    logic rot_done;
  } erg_status_t;

endpackage

>>> hdl/euclidean_rhythm_generator_unit.sv
// Top level of the euclidean rhythm generator
//
//   channel  direction  handshake            payload
//   in_      request    in_valid / in_stall  in_step_count, in_hit_count, in_rotation
//   out_     result     out_valid/out_stall  out_pattern_bits
//
// One request at a time: the serial divider produces NW = clog2(STEP_LIMIT+1) quotient
// bits per remainder level, the tree walk visits one node per cycle, normalization
// rotates up to the step count times and the rotation input is applied one step at a
// time. Zero steps or zero hits go straight from the check to the finish state. Reset
// is synchronous, active low, and clears the controller and result valid. A stalled
// result holds the next request in its last state.
`include "assert_macros.svh"

module euclidean_rhythm_generator_unit
  import erg_pkg::*;
#(
  parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [STEP_W-1:0] in_step_count,
  input  logic [HIT_W-1:0]  in_hit_count,
  input  logic [ROT_W-1:0]  in_rotation,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PAT_W-1:0]  out_pattern_bits
);

  erg_cmd_t    cmd;
  erg_status_t st;

  // Sequencer
  erg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath
  erg_datapath #(
    .STEP_LIMIT (STEP_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .st           (st),
    .step_count   (in_step_count),
    .hit_count    (in_hit_count),
    .rotation     (in_rotation),
    .pattern_bits (out_pattern_bits)
  );

  // Checks
  `ERG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ERG_ASSERT_IMPLY(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))
  `ERG_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid && !in_stall)

endmodule

>>> hdl/erg_ctrl.sv
// Sequencing state machine of the euclidean rhythm generator
module erg_ctrl
  import erg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  erg_status_t st,
  output erg_cmd_t    cmd
);

  erg_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.zero_case) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.level_wr = 1'b1;
        state_nxt    = st.lvl_more ? ST_DIV : ST_EXPAND;
      end
      ST_EXPAND: begin
        if (st.exp_done) state_nxt = ST_NORM;
        else cmd.exp_step = 1'b1;
      end
      ST_NORM: begin
        if (st.norm_done) state_nxt = ST_ROT;
        else cmd.norm_step = 1'b1;
      end
      ST_ROT: begin
        if (st.rot_done) state_nxt = ST_FINISH;
        else cmd.rot_step = 1'b1;
      end
      ST_FINISH: begin
        // hold the pattern until the result register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/erg_datapath.sv
// Remainder recurrence, level tree walk and rotation datapath
module erg_datapath
  import erg_pkg::*;
#(
  parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic              clk,
  input  erg_cmd_t          cmd,
  output erg_status_t       st,
  input  logic [STEP_W-1:0] step_count,
  input  logic [HIT_W-1:0]  hit_count,
  input  logic [ROT_W-1:0]  rotation,
  output logic [PAT_W-1:0]  pattern_bits
);

  localparam int SLOTS     = STEP_LIMIT + 2;
  localparam int NW        = $clog2(STEP_LIMIT + 1);
  localparam int CW        = $clog2(STEP_LIMIT + 2);
  localparam int SW        = $clog2(STEP_LIMIT);
  localparam int DW        = $clog2(NW);
  // remainders at least halve every two levels, which bounds the tree height
  localparam int LVL_BOUND = 2 * $clog2(STEP_LIMIT) + 2;
  localparam int LVL_DEPTH = (SLOTS < LVL_BOUND) ? SLOTS : LVL_BOUND;
  localparam int LW        = $clog2(LVL_DEPTH);

  // Request operands
  logic [NW-1:0]         n_r, n_nxt, h_r, h_nxt;
  logic [ROT_W-1:0]      rc_r, rc_nxt;
  // Shift-subtract divider
  logic [NW-1:0]         acc_r, acc_nxt, quo_r, quo_nxt, dsr_r, dsr_nxt;
  logic [DW-1:0]         dcnt_r, dcnt_nxt;
  logic [LW-1:0]         lvl_r, lvl_nxt;
  // Level tables and walk state
  logic [NW-1:0]         cnt_r [LVL_DEPTH];
  logic [NW-1:0]         cnt_nxt [LVL_DEPTH];
  logic [NW-1:0]         rem_r [LVL_DEPTH];
  logic [NW-1:0]         rem_nxt [LVL_DEPTH];
  logic [CW-1:0]         it_r [LVL_DEPTH];
  logic [CW-1:0]         it_nxt [LVL_DEPTH];
  logic                  via_r [LVL_DEPTH];
  logic                  via_nxt [LVL_DEPTH];
  logic [LW-1:0]         cur_r, cur_nxt, top_r, top_nxt;
  logic [NW-1:0]         pos_r, pos_nxt, nc_r, nc_nxt;
  logic [STEP_LIMIT-1:0] pat_r, pat_nxt;
  logic [PAT_W-1:0]      out_pat_r, out_pat_nxt;

  // Combinational helpers
  logic [NW-1:0]         n_ld, h_ld;
  logic [NW:0]           div_t, div_diff;
  logic                  div_ge;
  logic [LW-1:0]         lvl_inc;
  logic [CW-1:0]         c_cur, i_cur;
  logic                  rm_nz, do_rep, do_rem, do_ret, leaf, emit_bit;
  logic [LW-1:0]         child;
  logic [STEP_LIMIT-1:0] rot_p;

  // Clamp the step count and the hit count
  always_comb begin
    n_ld = (32'(step_count) > STEP_LIMIT) ? NW'(STEP_LIMIT) : NW'(step_count);
    h_ld = (32'(hit_count) > 32'(n_ld)) ? n_ld : NW'(hit_count);
  end

  // One restoring division step
  always_comb begin
    div_t    = {acc_r, quo_r[NW-1]};
    div_ge   = (div_t >= {1'b0, dsr_r});
    div_diff = div_t - {1'b0, dsr_r};
  end

  assign lvl_inc = lvl_r + LW'(1);

  // Decode the current tree node
  always_comb begin
    c_cur  = CW'(cnt_r[cur_r]);
    i_cur  = it_r[cur_r];
    rm_nz  = (rem_r[cur_r] != '0);
    do_rep = (i_cur < c_cur);
    do_rem = !do_rep && (i_cur == c_cur) && rm_nz;
    do_ret = !do_rep && !do_rem;
    leaf     = do_rep ? (cur_r == '0) : (cur_r <= LW'(1));
    emit_bit = do_rem && (cur_r == '0);
    child    = do_rep ? (cur_r - LW'(1)) : (cur_r - LW'(2));
  end

  // Rotate up by one within the step count
  always_comb begin
    for (int k = 0; k < STEP_LIMIT; k++) begin
      if (k == 0) rot_p[k] = pat_r[SW'(n_r - NW'(1))];
      else        rot_p[k] = pat_r[k-1] && (32'(k) < 32'(n_r));
    end
  end

  // Status to the controller
  always_comb begin
    st.zero_case = (n_r == '0) || (h_r == '0);
    st.div_last  = (dcnt_r == DW'(NW - 1));
    st.lvl_more  = (acc_r > NW'(1)) && (32'(lvl_r) + 2 < SLOTS);
    st.exp_done  = (pos_r == n_r) || (do_ret && (cur_r == top_r));
    st.norm_done = pat_r[0] || (nc_r == n_r) || (pat_r == '0);
    st.rot_done  = (rc_r == '0);
  end

  // Next values of the datapath registers
  always_comb begin
    n_nxt       = n_r;
    h_nxt       = h_r;
    rc_nxt      = rc_r;
    acc_nxt     = acc_r;
    quo_nxt     = quo_r;
    dsr_nxt     = dsr_r;
    dcnt_nxt    = dcnt_r;
    lvl_nxt     = lvl_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    it_nxt      = it_r;
    via_nxt     = via_r;
    cur_nxt     = cur_r;
    top_nxt     = top_r;
    pos_nxt     = pos_r;
    nc_nxt      = nc_r;
    pat_nxt     = pat_r;
    out_pat_nxt = out_pat_r;

    // capture the request
    if (cmd.load) begin
      n_nxt   = n_ld;
      h_nxt   = h_ld;
      rc_nxt  = rotation;
      pat_nxt = '0;
      nc_nxt  = '0;
    end

    // start the recurrence at level zero
    if (cmd.div_init) begin
      quo_nxt    = n_r - h_r;
      dsr_nxt    = h_r;
      acc_nxt    = '0;
      dcnt_nxt   = '0;
      lvl_nxt    = '0;
      rem_nxt[0] = h_r;
    end

    // advance the divider one quotient bit
    if (cmd.div_step) begin
      acc_nxt  = div_ge ? div_diff[NW-1:0] : div_t[NW-1:0];
      quo_nxt  = {quo_r[NW-2:0], div_ge};
      dcnt_nxt = dcnt_r + DW'(1);
    end

    // store count and remainder, then continue or set up the walk
    if (cmd.level_wr) begin
      cnt_nxt[lvl_r]   = quo_r;
      rem_nxt[lvl_inc] = acc_r;
      if (st.lvl_more) begin
        lvl_nxt  = lvl_inc;
        quo_nxt  = dsr_r;
        dsr_nxt  = acc_r;
        acc_nxt  = '0;
        dcnt_nxt = '0;
      end else begin
        cnt_nxt[lvl_inc] = dsr_r;
        it_nxt[lvl_inc]  = '0;
        top_nxt          = lvl_inc;
        cur_nxt          = lvl_inc;
        pos_nxt          = '0;
      end
    end

    // walk one node of the level tree
    if (cmd.exp_step) begin
      if (do_ret) begin
        cur_nxt = cur_r + (via_r[cur_r] ? LW'(2) : LW'(1));
      end else begin
        it_nxt[cur_r] = i_cur + CW'(1);
        if (leaf) begin
          pat_nxt[SW'(pos_r)] = emit_bit;
          pos_nxt             = pos_r + NW'(1);
        end else begin
          it_nxt[child]  = '0;
          via_nxt[child] = do_rem;
          cur_nxt        = child;
        end
      end
    end

    // rotate until step zero is a hit
    if (cmd.norm_step) begin
      pat_nxt = rot_p;
      nc_nxt  = nc_r + NW'(1);
    end

    // apply the requested rotation one step at a time
    if (cmd.rot_step) begin
      pat_nxt = rot_p;
      rc_nxt  = rc_r - ROT_W'(1);
    end

    if (cmd.out_load) out_pat_nxt = PAT_W'(pat_r);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    h_r       <= h_nxt;
    rc_r      <= rc_nxt;
    acc_r     <= acc_nxt;
    quo_r     <= quo_nxt;
    dsr_r     <= dsr_nxt;
    dcnt_r    <= dcnt_nxt;
    lvl_r     <= lvl_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    it_r      <= it_nxt;
    via_r     <= via_nxt;
    cur_r     <= cur_nxt;
    top_r     <= top_nxt;
    pos_r     <= pos_nxt;
    nc_r      <= nc_nxt;
    pat_r     <= pat_nxt;
    out_pat_r <= out_pat_nxt;
  end

  assign pattern_bits = out_pat_r;

endmodule

>>> sim/euclidean_rhythm_generator_unit_tb.sv
// Self-checking testbench of the euclidean rhythm generator unit
module euclidean_rhythm_generator_unit_tb;
  import erg_pkg::*;

  localparam int STEP_LIMIT  = STEP_LIMIT_DEF;
  localparam int LEVELS      = STEP_LIMIT + 2;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  // One request in flight with the pattern it should produce
  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic [HIT_W-1:0]  hits;
    logic [ROT_W-1:0]  rot;
    logic [PAT_W-1:0]  pattern;
  } pattern_req_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [STEP_W-1:0] in_step_count;
  logic [HIT_W-1:0]  in_hit_count;
  logic [ROT_W-1:0]  in_rotation;
  logic              out_valid;
  logic              out_stall;
  logic [PAT_W-1:0]  out_pattern_bits;

  pattern_req_t expected_patterns[$];
  pattern_req_t oldest_req;
  int           errors       = 0;
  int           sent_count   = 0;
  int           result_count = 0;
  int           odd_count    = 0;
  int           hold_request = 0;
  bit           tx_idle_on   = 1'b1;
  bit           rx_idle_on   = 1'b1;

  euclidean_rhythm_generator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_step_count    (in_step_count),
    .in_hit_count     (in_hit_count),
    .in_rotation      (in_rotation),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pattern_bits (out_pattern_bits)
  );

  // Clock with period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bjorklund pattern: clamp, remainder recurrence, level tree, normalize, rotate
  function automatic logic [PAT_W-1:0] euclid_pattern(input logic [STEP_W-1:0] steps_in,
                                                      input logic [HIT_W-1:0] hits_in,
                                                      input logic [ROT_W-1:0] rot_in);
    int unsigned n, h, divisor, depth, k, j, c, shift;
    int unsigned cnt[LEVELS];
    int unsigned rem[LEVELS];
    bit [63:0]   lvl_bits[LEVELS + 2];
    int unsigned lvl_len[LEVELS + 2];
    bit [63:0]   pat, mask;
    bit          more;
    n = 32'(steps_in);
    h = 32'(hits_in);
    if (n > STEP_LIMIT) n = STEP_LIMIT;
    if (h > n) h = n;
    if (n == 0 || h == 0) return '0;
    for (k = 0; k < LEVELS; k++) begin
      cnt[k] = 0;
      rem[k] = 0;
    end
    // Run the remainder and count recurrence
    divisor = n - h;
    rem[0]  = h;
    depth   = 0;
    more    = 1'b1;
    while (more) begin
      cnt[depth]     = divisor / rem[depth];
      rem[depth + 1] = divisor % rem[depth];
      divisor        = rem[depth];
      depth++;
      more = (rem[depth] > 1) && (depth + 1 < LEVELS);
    end
    cnt[depth] = divisor;
    // Expand the tree bottom up; slot 0 is a hit leaf, slot 1 a rest leaf
    lvl_bits[0] = 64'd1;
    lvl_len[0]  = 1;
    lvl_bits[1] = 64'd0;
    lvl_len[1]  = 1;
    for (k = 0; k <= depth; k++) begin
      j = k + 2;
      lvl_bits[j] = '0;
      lvl_len[j]  = 0;
      for (c = 0; c < cnt[k] + ((rem[k] != 0) ? 1 : 0); c++) begin
        shift = (c < cnt[k]) ? j - 1 : j - 2;
        if (lvl_len[j] < 64) lvl_bits[j] |= lvl_bits[shift] << lvl_len[j];
        lvl_len[j] = (lvl_len[j] + lvl_len[shift] > 64) ? 64 : lvl_len[j] + lvl_len[shift];
      end
    end
    mask = (64'd1 << n) - 64'd1;
    pat  = lvl_bits[depth + 2] & mask;
    // Rotate up by one until step 0 is a hit
    if (pat != 0 && n > 1) begin
      for (k = 0; k < n && pat[0] == 1'b0; k++) pat = ((pat << 1) | (pat >> (n - 1))) & mask;
    end
    k = rot_in % n;
    if (k != 0) pat = ((pat << k) | (pat >> (n - k))) & mask;
    return pat[PAT_W-1:0];
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  // Offer one request, hold it until accepted, then record its pattern
  task automatic send_request(input logic [STEP_W-1:0] steps, input logic [HIT_W-1:0] hits,
                              input logic [ROT_W-1:0] rot);
    int           gap;
    pattern_req_t entry;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 2) == 0) gap = gap_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_step_count <= steps;
    in_hit_count  <= hits;
    in_rotation   <= rot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.steps   = steps;
    entry.hits    = hits;
    entry.rot     = rot;
    entry.pattern = euclid_pattern(steps, hits, rot);
    expected_patterns.push_back(entry);
    sent_count++;
    if (steps == 0 || steps > STEP_LIMIT || hits == 0 || hits > steps) odd_count++;
  endtask

  // Extremes of the fields and typical rhythms
  task automatic test_extremes();
    send_request(5'd1, 5'd1, 4'd0);
    send_request(5'd16, 5'd16, 4'd15);
    send_request(5'd16, 5'd1, 4'd15);
    send_request(5'd16, 5'd1, 4'd0);
    send_request(5'd16, 5'd15, 4'd7);
    send_request(5'd8, 5'd3, 4'd0);
    send_request(5'd5, 5'd3, 4'd2);
    send_request(5'd13, 5'd5, 4'd9);
    send_request(5'd2, 5'd1, 4'd1);
  endtask

  // Zero steps and zero hits give an empty pattern
  task automatic test_zero_fields();
    send_request(5'd0, 5'd0, 4'd0);
    send_request(5'd0, 5'd31, 4'd15);
    send_request(5'd12, 5'd0, 4'd5);
    send_request(5'd31, 5'd0, 4'd3);
  endtask

  // Saturate the step count and clamp the hit count
  task automatic test_clamping();
    send_request(5'd17, 5'd4, 4'd1);
    send_request(5'd31, 5'd31, 4'd15);
    send_request(5'd24, 5'd7, 4'd10);
    send_request(5'd6, 5'd20, 4'd3);
    send_request(5'd9, 5'd10, 4'd0);
  endtask

  // Rotation at or above the step count wraps around
  task automatic test_rotation_wrap();
    send_request(5'd5, 5'd2, 4'd15);
    send_request(5'd3, 5'd1, 4'd3);
    send_request(5'd7, 5'd4, 4'd14);
  endtask

  // Hold off the receiver while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int k;
    tx_idle_on = 1'b0;
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 10; k++)
      send_request(STEP_W'($urandom_range(1, 16)), HIT_W'($urandom_range(1, 16)),
                   ROT_W'($urandom_range(0, 15)));
    tx_idle_on = 1'b1;
  endtask

  // Mostly well-formed random rhythms, some with fields out of range
  task automatic test_random_patterns(input int blocks);
    int                b, k, sel;
    logic [STEP_W-1:0] steps;
    logic [HIT_W-1:0]  hits;
    for (b = 0; b < blocks; b++) begin
      tx_idle_on = (b % 5) != 3;
      rx_idle_on = (b % 5) != 3 && (b % 7) != 5;
      for (k = 0; k < 100; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          steps = STEP_W'($urandom_range(1, 16));
          hits  = HIT_W'($urandom_range(1, 32'(steps)));
        end else if (sel < 88) begin
          steps = STEP_W'($urandom_range(1, 16));
          hits  = HIT_W'($urandom_range(1, 16));
        end else begin
          steps = STEP_W'($urandom);
          hits  = HIT_W'($urandom);
        end
        send_request(steps, hits, ROT_W'($urandom_range(0, 15)));
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Drive result stalls: random gaps plus a long hold-off when the bench requests one
  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) stall_left = gap_length();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest pending request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_patterns.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pattern %h",
                 $time, out_pattern_bits);
      end else begin
        oldest_req = expected_patterns.pop_front();
        if (out_pattern_bits !== oldest_req.pattern) begin
          errors++;
          $display("%0t: steps %0d hits %0d rot %0d: expected pattern %h, actual %h",
                   $time, oldest_req.steps, oldest_req.hits, oldest_req.rot,
                   oldest_req.pattern, out_pattern_bits);
        end
      end
    end
  end

  // Count cycles and end a hung run
  initial begin : watchdog
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d results pending",
             $time, CYCLE_LIMIT, expected_patterns.size());
    $display("Some tests failed");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_step_count = '0;
    in_hit_count  = '0;
    in_rotation   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_zero_fields();
    test_clamping();
    test_rotation_wrap();
    test_backpressure();
    test_random_patterns(15);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_patterns.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_patterns.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_patterns.size());
    end

    $display("Sent %0d requests (%0d with out-of-range fields), checked %0d patterns,",
             sent_count, odd_count, result_count);
    $display("with random gaps on both sides and one %0d-cycle result hold-off.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> euclidean_rhythm_generator_unit.f
+incdir+hdl
hdl/erg_pkg.sv
hdl/erg_ctrl.sv
hdl/erg_datapath.sv
hdl/euclidean_rhythm_generator_unit.sv
sim/euclidean_rhythm_generator_unit_tb.sv
